// ===== design/clmit_pkg.sv =====
// ----------------------------------------------------------------------------
// clmit_pkg: shared types and constants of the convolution layer
// Default geometry, item mode codes and the scaled tanh lookup table.
// ----------------------------------------------------------------------------
`default_nettype none

package clmit_pkg;

  // default geometry
  localparam int IN_MAPS_DEF  = 6;
  localparam int OUT_MAPS_DEF = 50;
  localparam int IN_SIZE_DEF  = 13;
  localparam int OUT_SIZE_DEF = 5;
  localparam int KERNEL_DEF   = 5;

  localparam int DATA_W = 16;

  // activation: |acc| in Q.24, table step 0.5 -> 23 fraction bits
  localparam int FRAC_W   = 23;
  localparam int ROM_W    = 13;
  localparam int SAT_BIT  = 27;  // |acc| >= 8.0
  localparam logic [ROM_W-1:0] ACT_MAX = 13'd7028;

  typedef enum logic [1:0] {
    MODE_WEIGHT  = 2'd0,
    MODE_FEATURE = 2'd1,
    MODE_COMPUTE = 2'd2
  } mode_e;

  // 1.7159*tanh(0.6667*x) in Q3.12 at x = 0, 0.5, ..., 8.0
  function automatic logic [ROM_W-1:0] act_rom(input logic [4:0] idx);
    logic [ROM_W-1:0] val;
    case (idx)
      5'd0:    val = 13'd0;
      5'd1:    val = 13'd2260;
      5'd2:    val = 13'd4096;
      5'd3:    val = 13'd5353;
      5'd4:    val = 13'd6115;
      5'd5:    val = 13'd6544;
      5'd6:    val = 13'd6776;
      5'd7:    val = 13'd6897;
      5'd8:    val = 13'd6961;
      5'd9:    val = 13'd6994;
      5'd10:   val = 13'd7010;
      5'd11:   val = 13'd7019;
      5'd12:   val = 13'd7024;
      5'd13:   val = 13'd7026;
      5'd14:   val = 13'd7027;
      5'd15:   val = 13'd7028;
      5'd16:   val = 13'd7028;
      default: val = ACT_MAX;
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

// ===== design/clmit_ram.sv =====
// ----------------------------------------------------------------------------
// clmit_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module clmit_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== design/clmit_act.sv =====
// ----------------------------------------------------------------------------
// clmit_act: scaled tanh activation
// Three stage pipeline: magnitude and table index, interpolation product,
// rounding and sign restore. Output is Q3.12.
// ----------------------------------------------------------------------------
`default_nettype none

module clmit_act #(
  parameter int ACC_W = 40
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start_i,
  input  wire logic signed [ACC_W-1:0]          acc_i,
  output logic                                  valid_o,
  output logic signed [clmit_pkg::DATA_W-1:0]   y_o
);
  import clmit_pkg::*;

  localparam int PROD_W = ROM_W + FRAC_W;

  logic [ACC_W-1:0]  mag;

  logic              va_q, vb_q;
  logic              neg_a_q, sat_a_q;
  logic [3:0]        idx_a_q;
  logic [FRAC_W-1:0] frac_a_q;

  logic              neg_b_q, sat_b_q;
  logic [ROM_W-1:0]  t0_b_q;
  logic [PROD_W-1:0] prod_b_q;

  logic [ROM_W-1:0]  t0, t1, diff;
  logic [PROD_W-1:0] rnd;
  logic [ROM_W-1:0]  y_mag;

  assign mag   = acc_i[ACC_W-1] ? (ACC_W'(0) - acc_i) : acc_i;
  assign t0    = act_rom({1'b0, idx_a_q});
  assign t1    = act_rom(5'({1'b0, idx_a_q}) + 5'd1);
  assign diff  = t1 - t0;
  assign rnd   = prod_b_q + PROD_W'(1 << (FRAC_W - 1));
  assign y_mag = sat_b_q ? ACT_MAX : t0_b_q + ROM_W'(rnd[PROD_W-1:FRAC_W]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q    <= 1'b0;
      vb_q    <= 1'b0;
      valid_o <= 1'b0;
    end else begin
      va_q    <= start_i;
      vb_q    <= va_q;
      valid_o <= vb_q;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    neg_a_q  <= acc_i[ACC_W-1];
    sat_a_q  <= |mag[ACC_W-1:SAT_BIT];
    idx_a_q  <= mag[SAT_BIT-1:FRAC_W];
    frac_a_q <= mag[FRAC_W-1:0];

    neg_b_q  <= neg_a_q;
    sat_b_q  <= sat_a_q;
    t0_b_q   <= t0;
    prod_b_q <= PROD_W'(diff) * PROD_W'(frac_a_q);

    // magnitude stays below 7029, so it fits Q3.12 without any clamp
    y_o <= neg_b_q ? -DATA_W'(y_mag) : DATA_W'(y_mag);
  end

endmodule

`default_nettype wire

// ===== design/conv_layer_multi_input_tanh.sv =====
// Write beats (weight or feature) are taken back to back while idle.
// Compute beat: setup, KERNEL*KERNEL*IN_MAPS+1 store reads (bias, then taps)
// through the single multiply-accumulate unit (151 by default), the MAC
// product and accumulate registers, the activation pipeline, result capture
// and output load; an out-of-range neuron loads zero without a MAC pass.
// The next beat is taken once the result sits in the output register.
// Reset clears control state only; both stores hold garbage until written.
// ----------------------------------------------------------------------------
// conv_layer_multi_input_tanh: convolution layer, 5x5 stride 2, tanh
// Weight and feature stores in RAM, one MAC walking each kernel window.
// ----------------------------------------------------------------------------
`default_nettype none

module conv_layer_multi_input_tanh #(
  parameter int IN_MAPS  = clmit_pkg::IN_MAPS_DEF,
  parameter int OUT_MAPS = clmit_pkg::OUT_MAPS_DEF,
  parameter int IN_SIZE  = clmit_pkg::IN_SIZE_DEF,
  parameter int OUT_SIZE = clmit_pkg::OUT_SIZE_DEF,
  parameter int KERNEL   = clmit_pkg::KERNEL_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic [1:0]                          mode_i,
  input  wire logic [12:0]                         addr_i,
  input  wire logic signed [clmit_pkg::DATA_W-1:0] value_i,
  input  wire logic [5:0]                          out_map_i,
  input  wire logic [2:0]                          out_row_i,
  input  wire logic [2:0]                          out_col_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic signed [clmit_pkg::DATA_W-1:0]      neuron_out_o
);
  import clmit_pkg::*;

  localparam int TAPS     = KERNEL * KERNEL * IN_MAPS;
  localparam int W_STRIDE = (KERNEL * KERNEL + 1) * IN_MAPS;
  localparam int W_DEPTH  = OUT_MAPS * W_STRIDE;
  localparam int F_PLANE  = IN_SIZE * IN_SIZE;
  localparam int F_DEPTH  = IN_MAPS * F_PLANE;
  localparam int WAW      = $clog2(W_DEPTH);
  localparam int FAW      = $clog2(F_DEPTH);
  localparam int WIN_MAX  = 2 * (OUT_SIZE - 1) + KERNEL - 1;
  localparam int F_MAX    = F_PLANE * (IN_MAPS - 1) + IN_SIZE * WIN_MAX + WIN_MAX;
  localparam int FCW      = $clog2(F_DEPTH + F_MAX + 1);
  localparam int CW       = $clog2(IN_MAPS + 1);
  localparam int KW       = $clog2(KERNEL + 1);
  localparam int RW       = $clog2(WIN_MAX + 2);
  localparam int PW       = 2 * DATA_W;
  localparam int ACC_W    = PW + $clog2(TAPS + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_RUN,
    ST_ACT,
    ST_OUT
  } state_e;

  state_e st_q;

  logic [5:0] map_q;
  logic [2:0] row_q, col_q;

  logic [WAW-1:0] wa_q;
  logic [FCW-1:0] fa_q, pix_q;
  logic [RW-1:0]  fr_q, fc_q;
  logic [CW-1:0]  c_q;
  logic [KW-1:0]  n_q, m_q;
  logic           first_q;

  logic s1_v_q, s1_bias_q, s1_gate_q, s1_last_q;
  logic s2_v_q, s2_bias_q, s2_last_q;
  logic signed [PW-1:0]    p_q;
  logic signed [ACC_W-1:0] acc_q;
  logic                    acc_done_q;

  logic signed [DATA_W-1:0] res_q;

  logic        accept, w_we, f_we, out_load;
  logic        in_range, in_win, c_last, n_last, m_last;
  logic [FCW-1:0] pix0;
  logic signed [DATA_W-1:0] w_rd, f_rd;
  logic        act_v;
  logic signed [DATA_W-1:0] act_y;

  assign in_ready_o = (st_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign w_we = accept && (mode_e'(mode_i) == MODE_WEIGHT) && (32'(addr_i) < W_DEPTH);
  assign f_we = accept && (mode_e'(mode_i) == MODE_FEATURE) && (32'(addr_i) < F_DEPTH);
  // output register free, or emptied on this edge
  assign out_load = (st_q == ST_OUT) && (!out_valid_o || out_ready_i);

  assign in_range = (32'(out_map_i) < OUT_MAPS) && (32'(out_row_i) < OUT_SIZE)
                 && (32'(out_col_i) < OUT_SIZE);
  assign in_win   = (32'(fr_q) < IN_SIZE) && (32'(fc_q) < IN_SIZE);
  assign c_last   = (c_q == CW'(IN_MAPS - 1));
  assign n_last   = (n_q == KW'(KERNEL - 1));
  assign m_last   = (m_q == KW'(KERNEL - 1));
  assign pix0     = FCW'(IN_SIZE * 2 * int'(row_q) + 2 * int'(col_q));

  clmit_ram #(.WIDTH(DATA_W), .DEPTH(W_DEPTH)) u_wram (
    .clk_i   (clk_i),
    .we_i    (w_we),
    .waddr_i (WAW'(addr_i)),
    .wdata_i (value_i),
    .raddr_i (wa_q),
    .rdata_o (w_rd)
  );

  clmit_ram #(.WIDTH(DATA_W), .DEPTH(F_DEPTH)) u_fram (
    .clk_i   (clk_i),
    .we_i    (f_we),
    .waddr_i (FAW'(addr_i)),
    .wdata_i (value_i),
    .raddr_i (fa_q[FAW-1:0]),
    .rdata_o (f_rd)
  );

  clmit_act #(.ACC_W(ACC_W)) u_act (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (acc_done_q),
    .acc_i   (acc_q),
    .valid_o (act_v),
    .y_o     (act_y)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      out_valid_o <= 1'b0;
      s1_v_q      <= 1'b0;
      s2_v_q      <= 1'b0;
      acc_done_q  <= 1'b0;
      first_q     <= 1'b0;
    end else begin
      s1_v_q     <= (st_q == ST_RUN);
      s2_v_q     <= s1_v_q;
      acc_done_q <= s2_v_q && s2_last_q;
      if (out_load) begin
        out_valid_o <= 1'b1;
      end else if (out_valid_o && out_ready_i) begin
        out_valid_o <= 1'b0;
      end

      case (st_q)
        ST_IDLE: begin
          if (in_valid_i && (mode_e'(mode_i) == MODE_COMPUTE)) begin
            map_q <= out_map_i;
            row_q <= out_row_i;
            col_q <= out_col_i;
            if (in_range) begin
              st_q <= ST_SETUP;
            end else begin
              res_q <= '0;
              st_q  <= ST_OUT;
            end
          end
        end
        ST_SETUP: begin
          wa_q    <= WAW'(int'(map_q) * W_STRIDE);
          pix_q   <= pix0;
          fa_q    <= pix0;
          fr_q    <= RW'(2 * int'(row_q));
          fc_q    <= RW'(2 * int'(col_q));
          c_q     <= '0;
          n_q     <= '0;
          m_q     <= '0;
          first_q <= 1'b1;
          st_q    <= ST_RUN;
        end
        ST_RUN: begin
          // first read fetches the bias, then one tap per cycle
          s1_bias_q <= first_q;
          s1_gate_q <= in_win;
          s1_last_q <= !first_q && c_last && n_last && m_last;
          wa_q      <= wa_q + WAW'(1);
          if (first_q) begin
            first_q <= 1'b0;
          end else if (!c_last) begin
            c_q  <= c_q + CW'(1);
            fa_q <= fa_q + FCW'(F_PLANE);
          end else if (!n_last) begin
            c_q   <= '0;
            n_q   <= n_q + KW'(1);
            fc_q  <= fc_q + RW'(1);
            pix_q <= pix_q + FCW'(1);
            fa_q  <= pix_q + FCW'(1);
          end else if (!m_last) begin
            c_q   <= '0;
            n_q   <= '0;
            m_q   <= m_q + KW'(1);
            fr_q  <= fr_q + RW'(1);
            fc_q  <= RW'(2 * int'(col_q));
            pix_q <= pix_q + FCW'(IN_SIZE - KERNEL + 1);
            fa_q  <= pix_q + FCW'(IN_SIZE - KERNEL + 1);
          end else begin
            st_q <= ST_ACT;
          end
        end
        ST_ACT: begin
          if (act_v) begin
            res_q <= act_y;
            st_q  <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_load) begin
            neuron_out_o <= res_q;
            st_q         <= ST_IDLE;
          end
        end
        default: begin
          st_q <= ST_IDLE;
        end
      endcase
    end
  end

  // MAC datapath, no reset
  always_ff @(posedge clk_i) begin
    s2_bias_q <= s1_bias_q;
    s2_last_q <= s1_last_q;
    if (s1_bias_q) begin
      p_q <= PW'(w_rd) <<< 12;  // bias to Q.24
    end else if (s1_gate_q) begin
      p_q <= w_rd * f_rd;
    end else begin
      p_q <= '0;
    end
    if (s2_v_q) begin
      acc_q <= s2_bias_q ? ACC_W'(p_q) : acc_q + ACC_W'(p_q);
    end
  end

  a_wr_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (w_we || f_we) |-> (st_q == ST_IDLE))
    else $error("store written outside idle");

  a_rd_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_v_q |-> ($past(st_q) == ST_RUN))
    else $error("MAC beat issued outside run");

  a_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_done_q |-> !s2_v_q)
    else $error("accumulator done with taps still in flight");

  a_act_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    act_v |-> (st_q == ST_ACT))
    else $error("activation result with no neuron pending");

  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> ($past(st_q) == ST_OUT))
    else $error("result loaded outside output state");

endmodule

`default_nettype wire
